// ===== rtl/blc_pkg.sv =====
// blc_pkg: shared types and constants of the block buffer cache controller
// no dependencies; used by every module in rtl/
package blc_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int BLOCK_BITS  = 24;

  // internal buffer number and free count widths
  localparam int BUF_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

  // fixed field widths of the request and result words
  localparam int OP_W       = 3;
  localparam int BLK_FW     = 24;
  localparam int IDX_FW     = 4;
  localparam int KIND_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 3'd0,
    OP_READ    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_DWRITE  = 3'd3,
    OP_RELEASE = 3'd4,
    OP_FLUSH   = 3'd5
  } blc_op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_ANSWER = 2'd2
  } blc_kind_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_RDCMD = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_ANS   = 5'b10000
  } blc_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BLK_FW-1:0] block_number;
    logic [IDX_FW-1:0] buffer_index;
  } blc_req_t;

  typedef struct packed {
    blc_kind_e         kind;
    logic [IDX_FW-1:0] buffer_slot;
    logic [BLK_FW-1:0] disk_block;
    logic              hit;
    logic              none_free;
    logic              last;
  } blc_res_t;

  // broadcast update for the buffer cells, applied by the selected cell
  typedef struct packed {
    logic [BLOCK_BITS-1:0] key;
    logic                  set_tag;
    logic                  set_valid;
    logic                  set_dirty;
    logic                  clr_dirty;
    logic                  set_done;
    logic                  clr_done;
    logic                  set_onl;
    logic                  clr_onl;
  } blc_cell_cmd_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] tag;
    logic                  valid;
    logic                  dirty;
    logic                  done;
    logic                  onl;
    logic                  match;
  } blc_cell_stat_t;

  // free list chain control
  typedef struct packed {
    logic             remove_en;
    logic [BUF_W-1:0] remove_buf;
    logic             append_en;
    logic [BUF_W-1:0] append_buf;
    logic [CNT_W-1:0] cnt;
  } blc_fl_cmd_t;

endpackage

// ===== rtl/blc_buf_cell.sv =====
// blc_buf_cell: metadata of one buffer (tag, valid, dirty, done, on-list)
// depends on blc_pkg; priority chains pass to the next cell
module blc_buf_cell import blc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  blc_cell_cmd_t  cmd_i,
  input  logic           sel_i,
  input  logic           match_seen_i,
  output logic           match_seen_o,
  input  logic           dirty_seen_i,
  output logic           dirty_seen_o,
  output logic           match_pick_o,
  output logic           dirty_pick_o,
  output blc_cell_stat_t stat_o
);

  logic [BLOCK_BITS-1:0] tag_q;
  logic valid_q, dirty_q, done_q, onl_q;
  logic match;

  assign match        = valid_q && (tag_q == cmd_i.key);
  assign match_pick_o = match && !match_seen_i;
  assign match_seen_o = match_seen_i || match;
  assign dirty_pick_o = dirty_q && !dirty_seen_i;
  assign dirty_seen_o = dirty_seen_i || dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      done_q  <= 1'b0;
      onl_q   <= 1'b1;
    end else if (sel_i) begin
      if (cmd_i.set_tag)   tag_q   <= cmd_i.key;
      if (cmd_i.set_valid) valid_q <= 1'b1;
      if (cmd_i.set_dirty) dirty_q <= 1'b1;
      if (cmd_i.clr_dirty) dirty_q <= 1'b0;
      if (cmd_i.set_done)  done_q  <= 1'b1;
      if (cmd_i.clr_done)  done_q  <= 1'b0;
      if (cmd_i.set_onl)   onl_q   <= 1'b1;
      if (cmd_i.clr_onl)   onl_q   <= 1'b0;
    end
  end

  assign stat_o = '{tag: tag_q, valid: valid_q, dirty: dirty_q, done: done_q,
                    onl: onl_q, match: match};

endmodule

// ===== rtl/blc_free_cell.sv =====
// blc_free_cell: one position of the lru free list
// depends on blc_pkg; takes the right neighbor's entry when the list closes up
module blc_free_cell import blc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BUF_W-1:0] cell_idx_i,
  input  blc_fl_cmd_t      cmd_i,
  input  logic             seen_i,
  output logic             seen_o,
  input  logic [BUF_W-1:0] next_ent_i,
  output logic [BUF_W-1:0] ent_o
);

  logic [BUF_W-1:0] ent_q, ent_d;
  logic             in_list, hit_here;

  assign in_list  = CNT_W'(cell_idx_i) < cmd_i.cnt;
  assign hit_here = cmd_i.remove_en && in_list && (ent_q == cmd_i.remove_buf);
  assign seen_o   = seen_i || hit_here;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.remove_en && seen_o) begin
      ent_d = next_ent_i;
    end else if (cmd_i.append_en && (CNT_W'(cell_idx_i) == cmd_i.cnt)) begin
      ent_d = cmd_i.append_buf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= cell_idx_i;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/block_buffer_cache_lru_top.sv =====
// block_buffer_cache_lru_top: buffer cache metadata controller, lru free list
// depends on blc_pkg, blc_buf_cell, blc_free_cell
//
//  channel   ports                     handshake             word
//  request   start, busy, req_i        start && !busy        blc_req_t
//  result    res_valid_o, res_o        res_valid_o, no stall blc_res_t
//
// steps: accept, execute, a disk read or flush step where needed, then answer
//   get/release/write: execute, then answer; the answer is registered and shows once the block is idle
//   read with a disk read: a disk read step before the answer; a miss write-back goes out of the execute step
//   flush: execute, a flush step per dirty buffer, a flush step that finds none left, answer
// the tag compare over all buffer cells and the free list close-up run in the
//   execute cycle; flush walks the dirty marks one buffer per cycle
// reset: valid, dirty and done marks clear, every buffer on the free list in order, count full
// the receiver cannot stall: each result word is shown for one cycle only
module block_buffer_cache_lru_top import blc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  blc_req_t req_i,
  output logic     res_valid_o,
  output blc_res_t res_o
);

  blc_state_e state_q, state_d;
  blc_req_t   req_q;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic              rd_need_q, rd_need_d;
  logic [IDX_FW-1:0] ans_slot_q, ans_slot_d;
  logic              ans_hit_q, ans_hit_d;
  logic              ans_nf_q, ans_nf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  blc_res_t          res_q, res_d;
  logic              res_valid_q, res_valid_d;

  // cell array wiring
  blc_cell_cmd_t          cmd;
  logic [NUM_BUFFERS-1:0] sel;
  blc_cell_stat_t         stat [NUM_BUFFERS];
  logic [NUM_BUFFERS:0]   match_seen, dirty_seen, fl_seen;
  logic [NUM_BUFFERS-1:0] match_pick, dirty_pick, match_raw, onl_vec;
  blc_fl_cmd_t            fl_cmd;
  logic [BUF_W-1:0]       fl_ent [NUM_BUFFERS+1];

  logic [BUF_W-1:0] hit_idx, dirty_idx, b_sel, head;
  logic             hit_any, dirty_any, idx_ok;

  assign match_seen[0] = 1'b0;
  assign dirty_seen[0] = 1'b0;
  assign fl_seen[0]    = 1'b0;
  // the last list cell closes up onto itself
  assign fl_ent[NUM_BUFFERS] = fl_ent[NUM_BUFFERS-1];

  for (genvar k = 0; k < NUM_BUFFERS; k++) begin : g_cells
    blc_buf_cell u_buf (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_i        (sel[k]),
      .match_seen_i (match_seen[k]),
      .match_seen_o (match_seen[k+1]),
      .dirty_seen_i (dirty_seen[k]),
      .dirty_seen_o (dirty_seen[k+1]),
      .match_pick_o (match_pick[k]),
      .dirty_pick_o (dirty_pick[k]),
      .stat_o       (stat[k])
    );

    blc_free_cell u_free (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (BUF_W'(k)),
      .cmd_i      (fl_cmd),
      .seen_i     (fl_seen[k]),
      .seen_o     (fl_seen[k+1]),
      .next_ent_i (fl_ent[k+1]),
      .ent_o      (fl_ent[k])
    );

    assign match_raw[k] = stat[k].match;
    assign onl_vec[k]   = stat[k].onl;
  end

  assign hit_any   = match_seen[NUM_BUFFERS];
  assign dirty_any = dirty_seen[NUM_BUFFERS];
  assign head      = fl_ent[0];

  // one-hot picks to buffer numbers
  always_comb begin
    hit_idx   = '0;
    dirty_idx = '0;
    for (int k = 0; k < NUM_BUFFERS; k++) begin
      if (match_pick[k]) hit_idx = hit_idx | BUF_W'(k);
      if (dirty_pick[k]) dirty_idx = dirty_idx | BUF_W'(k);
    end
  end

  assign idx_ok = int'(req_q.buffer_index) < NUM_BUFFERS;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    rd_need_d   = rd_need_q;
    ans_slot_d  = ans_slot_q;
    ans_hit_d   = ans_hit_q;
    ans_nf_d    = ans_nf_q;
    cnt_d       = cnt_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    b_sel       = '0;

    cmd         = '0;
    cmd.key     = BLOCK_BITS'(req_q.block_number);
    sel         = '0;
    fl_cmd      = '0;
    fl_cmd.cnt  = cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end

      ST_EXEC: begin
        ans_slot_d = '0;
        ans_hit_d  = 1'b0;
        ans_nf_d   = 1'b0;
        rd_need_d  = 1'b0;
        state_d    = ST_ANS;
        case (req_q.operation)
          OP_GET, OP_READ: begin
            if (hit_any) begin
              // hit: pull the buffer off the free list if it sits there
              b_sel = hit_idx;
              sel   = NUM_BUFFERS'(1) << b_sel;
              if (stat[b_sel].onl) begin
                fl_cmd.remove_en  = 1'b1;
                fl_cmd.remove_buf = b_sel;
                cmd.clr_onl       = 1'b1;
                cnt_d             = cnt_q - CNT_W'(1);
              end
              rd_need_d  = (req_q.operation == OP_READ) &&
                           !stat[b_sel].done && !stat[b_sel].dirty;
              ans_slot_d = IDX_FW'(b_sel);
              ans_hit_d  = 1'b1;
            end else if (cnt_q == '0) begin
              ans_nf_d = 1'b1;
            end else begin
              // miss: reuse the lru head, writing its old block back if dirty
              b_sel             = head;
              sel               = NUM_BUFFERS'(1) << b_sel;
              fl_cmd.remove_en  = 1'b1;
              fl_cmd.remove_buf = b_sel;
              cnt_d             = cnt_q - CNT_W'(1);
              cmd.clr_onl       = 1'b1;
              cmd.set_tag       = 1'b1;
              cmd.set_valid     = 1'b1;
              cmd.clr_dirty     = 1'b1;
              cmd.clr_done      = 1'b1;
              if (stat[b_sel].valid && stat[b_sel].dirty) begin
                res_valid_d       = 1'b1;
                res_d.kind        = KIND_WRITE;
                res_d.buffer_slot = IDX_FW'(b_sel);
                res_d.disk_block  = BLK_FW'(stat[b_sel].tag);
              end
              rd_need_d  = (req_q.operation == OP_READ);
              ans_slot_d = IDX_FW'(b_sel);
            end
            buf_d = b_sel;
            if (rd_need_d) state_d = ST_RDCMD;
          end

          OP_WRITE, OP_DWRITE, OP_RELEASE: begin
            ans_slot_d = req_q.buffer_index;
            if (idx_ok) begin
              b_sel = BUF_W'(req_q.buffer_index);
              sel   = NUM_BUFFERS'(1) << b_sel;
              if (stat[b_sel].valid) begin
                if (req_q.operation == OP_WRITE) begin
                  cmd.clr_dirty     = 1'b1;
                  cmd.set_done      = 1'b1;
                  res_valid_d       = 1'b1;
                  res_d.kind        = KIND_WRITE;
                  res_d.buffer_slot = IDX_FW'(b_sel);
                  res_d.disk_block  = BLK_FW'(stat[b_sel].tag);
                end else if (req_q.operation == OP_DWRITE) begin
                  cmd.set_dirty = 1'b1;
                  cmd.set_done  = 1'b1;
                end
              end
              // release to the tail of the lru list
              if (!stat[b_sel].onl) begin
                cmd.set_onl       = 1'b1;
                fl_cmd.append_en  = 1'b1;
                fl_cmd.append_buf = b_sel;
                cnt_d             = cnt_q + CNT_W'(1);
              end
            end
          end

          OP_FLUSH: begin
            state_d = ST_FLUSH;
          end

          default: begin
            state_d = ST_ANS;
          end
        endcase
      end

      ST_RDCMD: begin
        sel               = NUM_BUFFERS'(1) << buf_q;
        cmd.set_done      = 1'b1;
        res_valid_d       = 1'b1;
        res_d.kind        = KIND_READ;
        res_d.buffer_slot = IDX_FW'(buf_q);
        res_d.disk_block  = BLK_FW'(stat[buf_q].tag);
        state_d           = ST_ANS;
      end

      ST_FLUSH: begin
        // lowest dirty buffer first, one per cycle
        if (dirty_any) begin
          sel           = dirty_pick;
          cmd.clr_dirty = 1'b1;
          cmd.set_done  = 1'b1;
          if (stat[dirty_idx].valid) begin
            res_valid_d       = 1'b1;
            res_d.kind        = KIND_WRITE;
            res_d.buffer_slot = IDX_FW'(dirty_idx);
            res_d.disk_block  = BLK_FW'(stat[dirty_idx].tag);
          end
        end else begin
          state_d = ST_ANS;
        end
      end

      ST_ANS: begin
        res_valid_d       = 1'b1;
        res_d.kind        = KIND_ANSWER;
        res_d.buffer_slot = ans_slot_q;
        res_d.hit         = ans_hit_q;
        res_d.none_free   = ans_nf_q;
        res_d.last        = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_W'(NUM_BUFFERS);
      res_valid_q <= 1'b0;
      rd_need_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      rd_need_q   <= rd_need_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    buf_q      <= buf_d;
    ans_slot_q <= ans_slot_d;
    ans_hit_q  <= ans_hit_d;
    ans_nf_q   <= ans_nf_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // free count always matches the on-list marks
  a_cnt_onl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(onl_vec) == int'(cnt_q))
    else $error("free count and on-list marks disagree");

  // a block is mapped by at most one valid buffer
  a_tag_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_raw))
    else $error("duplicate valid tag");

  // the answer closes a request: the controller is idle when it shows
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> state_q == ST_IDLE)
    else $error("answer shown while busy");

  // commands only appear while the request is still in progress
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("command outside a request");

  // an accepted request goes straight to execution
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == ST_EXEC)
    else $error("accepted request not executed");

endmodule

// ===== tb/blc_checker.sv =====
// blc_checker: cache metadata predictor and result word scoreboard
// depends on blc_pkg; watches the request and result channels of the top level
module blc_checker import blc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  blc_req_t req_i,
  input  logic     res_valid_i,
  input  blc_res_t res_i,
  output logic     word_moved_o,
  output int       fail_count_o,
  output int       pending_o
);

  // predicted buffer metadata
  logic [BLK_FW-1:0] tag_q        [NUM_BUFFERS];
  logic              valid_q      [NUM_BUFFERS];
  logic              dirty_q      [NUM_BUFFERS];
  logic              done_q       [NUM_BUFFERS];
  logic              on_list_q    [NUM_BUFFERS];
  logic [IDX_FW-1:0] free_order_q [NUM_BUFFERS];
  int                free_count_q;

  blc_res_t owed_words_q[$];
  int       errs;

  assign word_moved_o = (start && !busy) || res_valid_i;

  function automatic void owe_word(input blc_kind_e k, input int slot,
                                   input logic [BLK_FW-1:0] blk, input logic h,
                                   input logic nf, input logic lst);
    blc_res_t w;
    w.kind        = k;
    w.buffer_slot = slot[IDX_FW-1:0];
    w.disk_block  = blk;
    w.hit         = h;
    w.none_free   = nf;
    w.last        = lst;
    owed_words_q.push_back(w);
  endfunction

  // take a buffer off the free list, closing up the gap
  function automatic void unlink_buffer(input int b);
    int p;
    int i;
    if (!on_list_q[b]) return;
    p = 0;
    while (p < free_count_q && int'(free_order_q[p]) != b) p++;
    for (i = p; i + 1 < free_count_q; i++) free_order_q[i] = free_order_q[i + 1];
    if (free_count_q > 0) free_count_q--;
    on_list_q[b] = 1'b0;
  endfunction

  function automatic void append_buffer(input int b);
    if (on_list_q[b] || free_count_q >= NUM_BUFFERS) return;
    free_order_q[free_count_q] = b[IDX_FW-1:0];
    free_count_q++;
    on_list_q[b] = 1'b1;
  endfunction

  // apply one accepted request and queue the commands and answer it causes
  function automatic void advance_cache(input blc_req_t rq);
    int   b;
    int   i;
    logic was_hit;
    b       = -1;
    was_hit = 1'b0;
    case (rq.operation)
      OP_GET, OP_READ: begin
        for (i = 0; i < NUM_BUFFERS; i++)
          if (b < 0 && valid_q[i] && tag_q[i] == rq.block_number) b = i;
        if (b >= 0) begin
          was_hit = 1'b1;
          unlink_buffer(b);
        end else if (free_count_q > 0) begin
          // miss: recycle the least recently released buffer
          b = int'(free_order_q[0]);
          unlink_buffer(b);
          if (valid_q[b] && dirty_q[b])
            owe_word(KIND_WRITE, b, tag_q[b], 1'b0, 1'b0, 1'b0);
          dirty_q[b] = 1'b0;
          done_q[b]  = 1'b0;
          tag_q[b]   = rq.block_number;
          valid_q[b] = 1'b1;
        end
        if (b < 0) begin
          owe_word(KIND_ANSWER, 0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
          if (rq.operation == OP_READ && !done_q[b] && !dirty_q[b]) begin
            owe_word(KIND_READ, b, tag_q[b], 1'b0, 1'b0, 1'b0);
            done_q[b] = 1'b1;
          end
          owe_word(KIND_ANSWER, b, '0, was_hit, 1'b0, 1'b1);
        end
      end
      OP_WRITE, OP_DWRITE, OP_RELEASE: begin
        b = int'(rq.buffer_index);
        if (b >= NUM_BUFFERS) begin
          owe_word(KIND_ANSWER, b, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          if (rq.operation == OP_WRITE && valid_q[b]) begin
            dirty_q[b] = 1'b0;
            owe_word(KIND_WRITE, b, tag_q[b], 1'b0, 1'b0, 1'b0);
            done_q[b] = 1'b1;
          end else if (rq.operation == OP_DWRITE && valid_q[b]) begin
            dirty_q[b] = 1'b1;
            done_q[b]  = 1'b1;
          end
          append_buffer(b);
          owe_word(KIND_ANSWER, b, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_FLUSH: begin
        for (i = 0; i < NUM_BUFFERS; i++) begin
          if (dirty_q[i]) begin
            dirty_q[i] = 1'b0;
            if (valid_q[i]) owe_word(KIND_WRITE, i, tag_q[i], 1'b0, 1'b0, 1'b0);
            done_q[i] = 1'b1;
          end
        end
        owe_word(KIND_ANSWER, 0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: owe_word(KIND_ANSWER, 0, '0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blc_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_q[i]        = '0;
        valid_q[i]      = 1'b0;
        dirty_q[i]      = 1'b0;
        done_q[i]       = 1'b0;
        on_list_q[i]    = 1'b1;
        free_order_q[i] = IDX_FW'(i);
      end
      free_count_q = NUM_BUFFERS;
      owed_words_q.delete();
      errs         = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare before predicting: a request never answers on its own edge
      if (res_valid_i) begin
        if (owed_words_q.size() == 0) begin
          errs++;
          $error("result word with nothing outstanding: %p", res_i);
        end else begin
          want = owed_words_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_i.kind));
          check_field("buffer_slot", 32'(want.buffer_slot), 32'(res_i.buffer_slot));
          check_field("disk_block", 32'(want.disk_block), 32'(res_i.disk_block));
          check_field("hit", 32'(want.hit), 32'(res_i.hit));
          check_field("none_free", 32'(want.none_free), 32'(res_i.none_free));
          check_field("last", 32'(want.last), 32'(res_i.last));
        end
      end
      if (start && !busy) advance_cache(req_i);
      fail_count_o <= errs;
      pending_o    <= owed_words_q.size();
    end
  end

endmodule

// ===== tb/tb_block_buffer_cache_lru_top.sv =====
// tb_block_buffer_cache_lru_top: stimulus and verdict for the buffer cache controller
// depends on blc_pkg, block_buffer_cache_lru_top and tb/blc_checker
module tb_block_buffer_cache_lru_top;
  import blc_pkg::*;

  localparam int RANDOM_WORDS   = 450;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int POOL_SIZE      = 24;

  // operation codes the block treats as undefined
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  blc_req_t req_i  = '0;
  logic     busy;
  logic     res_valid_o;
  blc_res_t res_o;

  logic word_moved;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  // block numbers reused often so that hits, evictions and stale tags show up
  logic [BLK_FW-1:0] block_pool [POOL_SIZE];

  always #5 clk_i = ~clk_i;

  block_buffer_cache_lru_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  blc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .word_moved_o(word_moved),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // watchdog: too long without any word crossing either channel
  always @(posedge clk_i) begin
    if (!rst_ni || word_moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic blc_req_t make_req(input logic [OP_W-1:0] op,
                                        input logic [BLK_FW-1:0] blk,
                                        input int idx);
    blc_req_t rq;
    rq.operation    = op;
    rq.block_number = blk;
    rq.buffer_index = idx[IDX_FW-1:0];
    return rq;
  endfunction

  // random request; draining favors lookups so the free list runs dry,
  // otherwise hand-backs dominate and refill it
  function automatic blc_req_t random_request(input bit draining);
    int                roll;
    logic [OP_W-1:0]   op;
    logic [BLK_FW-1:0] blk;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
    end else if (roll < 6) begin
      op = OP_FLUSH;
    end else if (roll < (draining ? 76 : 32)) begin
      op = $urandom_range(0, 1) ? OP_READ : OP_GET;
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_WRITE;
        1:       op = OP_DWRITE;
        default: op = OP_RELEASE;
      endcase
    end
    if ($urandom_range(0, 3) == 0) blk = BLK_FW'($urandom());
    else blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
    return make_req(op, blk, $urandom_range(0, NUM_BUFFERS - 1));
  endfunction

  // hold start high until the block takes the word
  task automatic send_word(input blc_req_t rq);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  // drop start for a number of cycles between bursts
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  int burst_left;
  int phase_left;
  bit draining;

  // send one word, then maybe end the burst with a random gap
  task automatic send_paced(input blc_req_t rq);
    send_word(rq);
    burst_left--;
    if (burst_left <= 0) begin
      hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 8);
    end
  endtask

  initial begin
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = BLK_FW'($urandom());
    burst_left = $urandom_range(1, 8);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part: buffer 0 takes block zero, buffer 1 the all-ones block
    send_paced(make_req(OP_GET,     '0, 0));             // miss on a never-valid tag
    send_paced(make_req(OP_GET,     '0, 0));             // hit, off the list
    send_paced(make_req(OP_READ,    '1, 15));            // miss, disk read issued
    send_paced(make_req(OP_READ,    '1, 0));             // hit with data present
    send_paced(make_req(OP_DWRITE,  '0, 1));             // mark buffer 1 dirty
    send_paced(make_req(OP_READ,    '1, 0));             // dirty hit, no disk read
    send_paced(make_req(OP_RELEASE, '0, 0));
    send_paced(make_req(OP_RELEASE, '1, 0));             // already on the list
    send_paced(make_req(OP_WRITE,   '0, 5));             // unmapped buffer
    send_paced(make_req(OP_FLUSH,   '1, 15));            // writes buffer 1 back
    send_paced(make_req(OP_DWRITE,  '0, 0));             // dirty while on the list
    send_paced(make_req(OP_FLUSH,   '0, 0));
    send_paced(make_req(OP_WRITE,   '1, 0));             // write-through command
    send_paced(make_req(OP_UNDEF_LO, '1, 15));
    send_paced(make_req(OP_UNDEF_HI, 24'h5a5a5a, 10));
    send_paced(make_req(OP_RELEASE, '1, 15));            // unmapped, already on the list
    send_paced(make_req(OP_READ,    24'h800000, 8));
    send_paced(make_req(OP_GET,     24'h7fffff, 7));

    // random part in alternating drain and refill phases
    draining   = 1'b1;
    phase_left = $urandom_range(20, 60);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        draining   = !draining;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      send_paced(random_request(draining));
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // stray words after the last answer still count as failures
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
